// ===== hdl/uart_rx_idle_frame_buffer_top_macros.svh =====
// Assertion macros used by the frame buffer controller.
`ifndef UART_RX_IDLE_FRAME_BUFFER_TOP_MACROS_SVH
`define UART_RX_IDLE_FRAME_BUFFER_TOP_MACROS_SVH

// Same-cycle implication, clocked on aclk and quiet while aresetn is low.
`define URIFB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and quiet while aresetn is low.
`define URIFB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/urifb_pkg.sv =====
// Types, codes and sizing constants of the receive frame buffer.
package urifb_pkg;

    localparam int BUFFER_DEPTH   = 64;
    localparam int ADDR_W         = $clog2(BUFFER_DEPTH);
    localparam int CNT_W          = $clog2(BUFFER_DEPTH + 1);
    localparam int RESULT_MAX     = 64;
    localparam int N_W            = $clog2(RESULT_MAX + 1);
    localparam int LIM_W          = 7;
    localparam int OUT_CNT_W      = 7;
    localparam int MIN_W          = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam logic [7:0] IDLE_LIMIT_RESET = 8'd30;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_READ = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NOTICE = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_EMPTY  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    // Request to load the output register, from the controller to the top level.
    typedef struct packed {
        logic                 load;
        kind_t                kind;
        logic                 last;
        logic [OUT_CNT_W-1:0] count;
        logic                 from_ram;
    } out_load_t;

endpackage

// ===== hdl/urifb_ram.sv =====
// Simple dual-port synchronous RAM with registered, enabled read.
module urifb_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/urifb_ctrl.sv =====
// Command decoder, idle timer and read sequencer of the frame buffer.
module urifb_ctrl
    import urifb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    input  logic [7:0]        s_rx_byte,
    input  logic [7:0]        s_tick_ms,
    input  logic [LIM_W-1:0]  s_read_limit,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    input  logic              out_free,
    output out_load_t         out_load,
    output logic              ram_wr_en,
    output logic [ADDR_W-1:0] ram_wr_addr,
    output logic [7:0]        ram_wr_data,
    output logic              ram_rd_en,
    output logic [ADDR_W-1:0] ram_rd_addr
);

`include "uart_rx_idle_frame_buffer_top_macros.svh"

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [CNT_W-1:0] snapshot_reg, snapshot_next;
    logic [7:0]       timer_reg, timer_next;
    logic             pending_reg, pending_next;
    logic [7:0]       limit_reg, limit_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic [N_W-1:0]   issue_reg, issue_next;
    logic [N_W-1:0]   emit_reg, emit_next;
    logic             rd_pend_reg, rd_pend_next;

    logic             accept;
    logic [8:0]       t_sum;
    logic [7:0]       t_add;
    logic [7:0]       t_new;
    logic [MIN_W-1:0] lim_ext;
    logic [MIN_W-1:0] cnt_ext;
    logic [MIN_W-1:0] n_min;
    logic [N_W-1:0]   n_calc;
    logic             last_byte;

    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Idle timer: add the tick while below the limit, saturating at 255.
    assign t_sum = {1'b0, timer_reg} + {1'b0, s_tick_ms};
    assign t_add = t_sum[8] ? 8'hFF : t_sum[7:0];
    assign t_new = (timer_reg < limit_reg) ? t_add : timer_reg;

    // Run length of a read: smallest of the request, the fill and the result cap.
    assign lim_ext = MIN_W'(s_read_limit);
    assign cnt_ext = MIN_W'(rx_count_reg);
    always_comb begin
        n_min = (lim_ext < cnt_ext) ? lim_ext : cnt_ext;
        if (n_min > MIN_W'(RESULT_MAX)) begin
            n_min = MIN_W'(RESULT_MAX);
        end
        n_calc = N_W'(n_min);
    end

    assign last_byte = ((emit_reg + N_W'(1)) == n_reg);

    always_comb begin
        state_next    = state_reg;
        rx_count_next = rx_count_reg;
        snapshot_next = snapshot_reg;
        timer_next    = timer_reg;
        pending_next  = pending_reg;
        limit_next    = cfg_valid ? cfg_data : limit_reg;
        n_next        = n_reg;
        issue_next    = issue_reg;
        emit_next     = emit_reg;
        rd_pend_next  = rd_pend_reg;

        out_load.load     = 1'b0;
        out_load.kind     = KIND_NOTICE;
        out_load.last     = 1'b1;
        out_load.count    = '0;
        out_load.from_ram = 1'b0;

        ram_wr_en   = 1'b0;
        ram_wr_addr = ADDR_W'(rx_count_reg);
        ram_wr_data = s_rx_byte;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ADDR_W'(issue_reg);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        CMD_BYTE: begin
                            if (rx_count_reg < CNT_W'(BUFFER_DEPTH)) begin
                                ram_wr_en     = 1'b1;
                                rx_count_next = rx_count_reg + CNT_W'(1);
                            end
                        end
                        CMD_TICK: begin
                            if (rx_count_reg == '0) begin
                                snapshot_next = '0;
                            end else if (rx_count_reg != snapshot_reg) begin
                                snapshot_next = rx_count_reg;
                                timer_next    = '0;
                            end else if (t_new >= limit_reg) begin
                                timer_next    = '0;
                                pending_next  = 1'b1;
                                if (!pending_reg) begin
                                    out_load.load  = 1'b1;
                                    out_load.kind  = KIND_NOTICE;
                                    out_load.count = OUT_CNT_W'(rx_count_reg);
                                end
                            end else begin
                                timer_next = t_new;
                            end
                        end
                        CMD_READ: begin
                            rx_count_next = '0;
                            pending_next  = 1'b0;
                            if (n_calc == '0) begin
                                out_load.load = 1'b1;
                                out_load.kind = KIND_EMPTY;
                            end else begin
                                state_next   = ST_READ;
                                n_next       = n_calc;
                                issue_next   = '0;
                                emit_next    = '0;
                                rd_pend_next = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // One RAM word may wait for the output register; the RAM output
                // holds it because no new read is issued until it moves on.
                out_load.load     = rd_pend_reg && out_free;
                out_load.kind     = KIND_DATA;
                out_load.last     = last_byte;
                out_load.count    = OUT_CNT_W'(n_reg);
                out_load.from_ram = 1'b1;
                ram_rd_en = (issue_reg < n_reg) && (!rd_pend_reg || out_load.load);
                if (ram_rd_en) begin
                    issue_next = issue_reg + N_W'(1);
                end
                rd_pend_next = ram_rd_en || (rd_pend_reg && !out_load.load);
                if (out_load.load) begin
                    emit_next = emit_reg + N_W'(1);
                    if (last_byte) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rx_count_reg <= '0;
            snapshot_reg <= '0;
            timer_reg    <= '0;
            pending_reg  <= 1'b0;
            limit_reg    <= IDLE_LIMIT_RESET;
            rd_pend_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rx_count_reg <= rx_count_next;
            snapshot_reg <= snapshot_next;
            timer_reg    <= timer_next;
            pending_reg  <= pending_next;
            limit_reg    <= limit_next;
            rd_pend_reg  <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        issue_reg <= issue_next;
        emit_reg  <= emit_next;
    end

    `URIFB_ASSERT_IMP(a_count_bound, 1'b1, rx_count_reg <= CNT_W'(BUFFER_DEPTH),
        "buffer fill count exceeds the buffer depth")
    `URIFB_ASSERT_IMP(a_read_order, state_reg == ST_READ,
        (emit_reg <= issue_reg) && (issue_reg <= n_reg),
        "read run emitted more bytes than it fetched")
    `URIFB_ASSERT_NXT(a_last_ends_run,
        (state_reg == ST_READ) && out_load.load && out_load.last,
        state_reg == ST_IDLE, "read run did not end after its last byte")

endmodule

// ===== hdl/uart_rx_idle_frame_buffer_top.sv =====
// Top level of the UART receive frame buffer with idle-gap framing.
//
// The input channel (s_valid/s_ready) carries one command item per transfer:
// a received byte, a time tick in milliseconds, or a read request. The result
// channel (m_valid/m_ready) returns frame notices, data bytes and empty-read
// markers from a registered output stage. The cfg channel writes idle_limit,
// the idle time in milliseconds that closes a frame; cfg_ready is always high.
// Bytes are stored in a 64-entry synchronous RAM, so buffered data is never
// cleared; only fill count, snapshot, timer, flags, state and limit are reset.
// Byte and tick items are taken one per cycle while idle and out_free is high;
// a tick that closes a frame shows its notice on m_valid in the cycle after it
// is accepted. A read keeps s_ready low until its last byte enters the output
// register. Each byte passes the read state, the registered RAM fetch and the
// output register; bytes follow one per cycle while m_ready stays high, set by
// the single RAM read port. An empty read is answered in the cycle after it.
// When the receiver stalls, the output register holds its item, at most one
// fetched byte waits at the RAM output, and s_ready stays low until the
// output register can take a new result.
// After aresetn (synchronous, active low) the buffer is empty, the timer and
// frame flag are clear and idle_limit is 30.
module uart_rx_idle_frame_buffer_top
    import urifb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_command,
    input  logic [7:0]           s_rx_byte,
    input  logic [7:0]           s_tick_ms,
    input  logic [LIM_W-1:0]     s_read_limit,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [7:0]           m_data_byte,
    output logic                 m_last,
    output logic [OUT_CNT_W-1:0] m_byte_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [7:0]           cfg_data
);

    out_load_t             out_load;
    logic                  out_free;
    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [7:0]            ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [7:0]            ram_rd_data;

    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_kind_reg;
    logic [7:0]            m_data_byte_reg;
    logic                  m_last_reg;
    logic [OUT_CNT_W-1:0]  m_byte_count_reg;

    // The output register can take a result when it is empty or being drained.
    assign out_free = !m_valid_reg || m_ready;

    urifb_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_rx_byte    (s_rx_byte),
        .s_tick_ms    (s_tick_ms),
        .s_read_limit (s_read_limit),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .out_free     (out_free),
        .out_load     (out_load),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .ram_rd_en    (ram_rd_en),
        .ram_rd_addr  (ram_rd_addr)
    );

    urifb_ram #(
        .DEPTH  (BUFFER_DEPTH),
        .WIDTH  (8),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Notices and empty reads carry a zero data byte.
    always_ff @(posedge aclk) begin
        if (out_load.load) begin
            m_kind_reg       <= out_load.kind;
            m_data_byte_reg  <= out_load.from_ram ? ram_rd_data : 8'd0;
            m_last_reg       <= out_load.last;
            m_byte_count_reg <= out_load.count;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_data_byte  = m_data_byte_reg;
    assign m_last       = m_last_reg;
    assign m_byte_count = m_byte_count_reg;

endmodule
